[rtl/bwc_pkg.sv]
// ----------------------------------------------------------------------------
// bwc_pkg
// Shared types and constants for the compact-target block work divider.
// ----------------------------------------------------------------------------
package bwc_pkg;

  localparam int unsigned WorkW     = 256;
  localparam int unsigned WordW     = 64;
  localparam int unsigned NumWords  = WorkW / WordW;
  localparam int unsigned StepsCell = 4;
  localparam int unsigned NumCells  = WorkW / StepsCell;

  // one division in flight: partial remainder, divisor, quotient so far
  typedef struct packed {
    logic             vld;
    logic             inv;
    logic [WorkW-1:0] rem;
    logic [WorkW-1:0] den;
    logic [WorkW-1:0] quo;
  } bwc_item_t;

endpackage

[rtl/bwc_decode.sv]
// ----------------------------------------------------------------------------
// bwc_decode
// Expands a compact difficulty word into the divisor target+1 and flags bad
// targets (negative, overflowing or zero).
// ----------------------------------------------------------------------------
module bwc_decode import bwc_pkg::*; (
  input  logic [31:0]      compact_bits_i,
  output logic [WorkW-1:0] den_o,
  output logic             inv_o
);

  logic [7:0]       size;
  logic [22:0]      mant;
  logic             neg;
  logic             ovf;
  logic [4:0]       up_bytes;
  logic [1:0]       dn_bytes;
  logic [WorkW-1:0] target;

  always_comb begin
    size     = compact_bits_i[31:24];
    mant     = compact_bits_i[22:0];
    neg      = (mant != '0) && compact_bits_i[23];
    ovf      = (mant != '0) && ((size > 8'd34) ||
               ((mant > 23'hff) && (size > 8'd33)) ||
               ((mant > 23'hffff) && (size > 8'd32)));
    up_bytes = 5'(size - 8'd3);
    dn_bytes = 2'(8'd3 - size);
    if (size <= 8'd3) begin
      target = WorkW'(mant >> {dn_bytes, 3'b000});
    end else begin
      target = WorkW'(mant) << {up_bytes, 3'b000};
    end
    inv_o = neg || ovf || (target == '0);
    // an all-ones divisor keeps invalid items harmless in the chain
    den_o = inv_o ? '1 : target + WorkW'(1);
  end

endmodule

[rtl/bwc_cell.sv]
// ----------------------------------------------------------------------------
// bwc_cell
// One divider cell: a restoring shift-subtract step per cycle, four quotient
// bits per item, then the item moves on to the next cell.
// ----------------------------------------------------------------------------
module bwc_cell import bwc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  bwc_item_t item_i,
  output bwc_item_t item_o
);

  bwc_item_t      item_q;
  bwc_item_t      item_d;
  bwc_item_t      cur;
  logic [WorkW:0] r2;
  logic [WorkW:0] diff;
  logic           ge;

  always_comb begin
    cur  = load_i ? item_i : item_q;
    // dividend bits below the leading one are all zero
    r2   = {cur.rem, 1'b0};
    ge   = r2 >= {1'b0, cur.den};
    diff = r2 - {1'b0, cur.den};
    item_d     = cur;
    item_d.rem = ge ? diff[WorkW-1:0] : r2[WorkW-1:0];
    item_d.quo = {cur.quo[WorkW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

[rtl/block_work_from_compact.sv]
// ----------------------------------------------------------------------------
// block_work_from_compact
// Expected block work 2^256/(target+1) from a compact difficulty word.
// ----------------------------------------------------------------------------
// An item is taken only in the hand-off phase, when busy_o is low (phase_q is 3),
// and gives four 64-bit words on consecutive cycles, least significant first,
// each marked by valid_o for one cycle; the receiver cannot stall them.
// The quotient comes from a row of 64 divider cells, each producing four
// quotient bits per item, so the rate is set by those four steps per cell;
// new items enter while earlier ones are still in the row.
module block_work_from_compact import bwc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [31:0]      compact_bits_i,
  output logic             valid_o,
  output logic [WordW-1:0] work_word_o,
  output logic [1:0]       word_index_o,
  output logic             last_word_o,
  output logic             target_invalid_o
);

  logic [1:0]       phase_q;
  logic             hand_off;
  logic             accept;
  logic [WorkW-1:0] dec_den;
  logic             dec_inv;
  bwc_item_t        in_q;
  bwc_item_t        in_d;
  bwc_item_t        chain [NumCells+1];
  logic             out_vld_q;
  logic             out_inv_q;
  logic [WorkW-1:0] out_quo_q;

  assign hand_off = (phase_q == 2'd3);
  assign busy_o   = !hand_off;
  assign accept   = start_i && hand_off;

  bwc_decode u_decode (
    .compact_bits_i (compact_bits_i),
    .den_o          (dec_den),
    .inv_o          (dec_inv)
  );

  always_comb begin
    in_d.vld = accept;
    in_d.inv = dec_inv;
    in_d.rem = WorkW'(1);
    in_d.den = dec_den;
    in_d.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      in_q      <= '0;
      out_vld_q <= 1'b0;
      out_inv_q <= 1'b0;
      out_quo_q <= '0;
    end else begin
      phase_q <= phase_q + 2'd1;
      if (hand_off) begin
        in_q      <= in_d;
        out_vld_q <= chain[NumCells].vld;
        out_inv_q <= chain[NumCells].inv;
        out_quo_q <= chain[NumCells].quo;
      end
    end
  end

  assign chain[0] = in_q;

  for (genvar gi = 0; gi < NumCells; gi++) begin : g_cell
    bwc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .load_i (hand_off),
      .item_i (chain[gi]),
      .item_o (chain[gi+1])
    );
  end

  always_comb begin
    case (phase_q)
      2'd0:    work_word_o = out_quo_q[0*WordW +: WordW];
      2'd1:    work_word_o = out_quo_q[1*WordW +: WordW];
      2'd2:    work_word_o = out_quo_q[2*WordW +: WordW];
      default: work_word_o = out_quo_q[3*WordW +: WordW];
    endcase
    if (out_inv_q) begin
      work_word_o = '0;
    end
  end

  assign valid_o          = out_vld_q;
  assign word_index_o     = phase_q;
  assign last_word_o      = (phase_q == 2'd3);
  assign target_invalid_o = out_inv_q;

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_word_o |=> valid_o)
    else $error("result run broken before last word");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && target_invalid_o |-> work_word_o == '0)
    else $error("invalid target with nonzero work");

  a_flag_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && word_index_o != 2'd0 |-> $stable(target_invalid_o))
    else $error("invalid flag changed within a run");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !$past(valid_o) |-> word_index_o == 2'd0)
    else $error("run did not start at word zero");

endmodule
